// ----- rtl/euler_rotation_matrix_assert.svh -----
// Assertion macros shared by the RTL files
`ifndef EULER_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ROTATION_MATRIX_ASSERT_SVH

// consequent in the same cycle as the antecedent
`define ERM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent delayed from the antecedent by the argument n
`define ERM_ASSERT_DLY(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- rtl/erm_pkg.sv -----
`default_nettype none

package erm_pkg;

  localparam int ANGLE_W = 16;
  localparam int ENTRY_W = 16;
  localparam int AXES    = 3;
  localparam int LANES   = 2 * AXES;
  localparam int ENTRIES = 9;
  localparam int TERMS   = 7;

  localparam int PREP_DEPTH = 4;
  localparam int CELL_DEPTH = 2;
  localparam int MIX_DEPTH  = 6;
  localparam int LATENCY    = PREP_DEPTH + CELL_DEPTH * TERMS + MIX_DEPTH;

  localparam int Q30_SH   = 30;
  localparam int ANG_SH   = 17;
  localparam int U_W      = ANGLE_W + ANG_SH;
  localparam int UR_W     = 32;
  localparam int T_W      = 31;
  localparam int X2_W     = 32;
  localparam int S_W      = 31;
  localparam int P_W      = 32;
  localparam int Q_W      = 30;
  localparam int RECIP_W  = 32;
  localparam int MAG_W    = 31;
  localparam int SUM_W    = 33;
  localparam int RND_SH   = 16;
  localparam int SAT_W    = SUM_W - RND_SH;

  localparam logic [UR_W-1:0]  PI_Q30      = 32'd3373259426;
  localparam logic [T_W-1:0]   HALF_PI_Q30 = 31'd1686629713;
  localparam logic [S_W-1:0]   ONE_Q30     = 31'h4000_0000;
  localparam logic [SUM_W-1:0] RND_HALF    = 33'd32768;
  localparam logic [SAT_W-1:0] Q14_MAX     = 17'd16384;

  // per-term shift, chosen so each reciprocal fits 32 bits and stays exact
  localparam int RECIP_SH [TERMS] = '{39, 39, 38, 38, 37, 36, 34};

  // ceil(2^sh / d) for d = 2k(2k+1), first cell holds the highest term
  localparam logic [RECIP_W-1:0] RECIP [TERMS] = '{
    RECIP_W'(((64'd1 << RECIP_SH[0]) + 64'd209) / 64'd210),
    RECIP_W'(((64'd1 << RECIP_SH[1]) + 64'd155) / 64'd156),
    RECIP_W'(((64'd1 << RECIP_SH[2]) + 64'd109) / 64'd110),
    RECIP_W'(((64'd1 << RECIP_SH[3]) + 64'd71) / 64'd72),
    RECIP_W'(((64'd1 << RECIP_SH[4]) + 64'd41) / 64'd42),
    RECIP_W'(((64'd1 << RECIP_SH[5]) + 64'd19) / 64'd20),
    RECIP_W'(((64'd1 << RECIP_SH[6]) + 64'd5) / 64'd6)
  };

  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  localparam int LN_SX = 0;
  localparam int LN_CX = 1;
  localparam int LN_SY = 2;
  localparam int LN_CY = 3;
  localparam int LN_SZ = 4;
  localparam int LN_CZ = 5;

  localparam int E00 = 0;
  localparam int E01 = 1;
  localparam int E02 = 2;
  localparam int E10 = 3;
  localparam int E11 = 4;
  localparam int E12 = 5;
  localparam int E20 = 6;
  localparam int E21 = 7;
  localparam int E22 = 8;

  typedef struct packed {
    logic [X2_W-1:0] x2;
    logic [T_W-1:0]  t;
    logic [S_W-1:0]  s;
  } lane_t;

  typedef struct packed {
    logic             valid;
    logic [LANES-1:0] neg;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/erm_prep.sv -----
`default_nettype none
`include "euler_rotation_matrix_assert.svh"

module erm_prep import erm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [ANGLE_W-1:0] angle_i [AXES],
  output ctl_t               ctl_o,
  output lane_t              lane_o [LANES]
);

  logic [PREP_DEPTH-1:0] vld_q;

  logic [ANGLE_W-1:0] mag      [AXES];
  logic [U_W-1:0]     uabs     [AXES];
  logic [AXES-1:0]    over1;
  logic [AXES-1:0]    over2;
  logic [UR_W-1:0]    u1_d     [AXES];
  logic [UR_W-1:0]    u1_q     [AXES];
  logic [AXES-1:0]    sfl1_d, sfl1_q, cfl1_d, cfl1_q;
  logic [T_W-1:0]     u2_d     [AXES];
  logic [T_W-1:0]     u2_q     [AXES];
  logic [AXES-1:0]    sfl2_q, cfl2_d, cfl2_q;
  logic [T_W-1:0]     ts_q     [AXES];
  logic [T_W-1:0]     tc_d     [AXES];
  logic [T_W-1:0]     tc_q     [AXES];
  logic [AXES-1:0]    sfl3_q, cfl3_q;
  logic [2*T_W-1:0]   sq_s     [AXES];
  logic [2*T_W-1:0]   sq_c     [AXES];
  lane_t              lane_d   [LANES];
  lane_t              lane_q   [LANES];
  logic [LANES-1:0]   neg_d, neg_q;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      mag[a]    = angle_i[a][ANGLE_W-1] ? ANGLE_W'(-angle_i[a]) : angle_i[a];
      uabs[a]   = U_W'(mag[a]) << ANG_SH;
      over1[a]  = uabs[a] > U_W'(PI_Q30);
      u1_d[a]   = over1[a] ? UR_W'(uabs[a] - U_W'(PI_Q30)) : UR_W'(uabs[a]);
      sfl1_d[a] = over1[a] ^ angle_i[a][ANGLE_W-1];
      cfl1_d[a] = over1[a];

      over2[a]  = u1_q[a] > UR_W'(HALF_PI_Q30);
      u2_d[a]   = over2[a] ? T_W'(PI_Q30 - u1_q[a]) : T_W'(u1_q[a]);
      cfl2_d[a] = cfl1_q[a] ^ over2[a];

      tc_d[a]   = HALF_PI_Q30 - u2_q[a];

      sq_s[a] = ts_q[a] * ts_q[a];
      sq_c[a] = tc_q[a] * tc_q[a];
      lane_d[2*a].x2   = sq_s[a][Q30_SH +: X2_W];
      lane_d[2*a].t    = ts_q[a];
      lane_d[2*a].s    = ONE_Q30;
      lane_d[2*a+1].x2 = sq_c[a][Q30_SH +: X2_W];
      lane_d[2*a+1].t  = tc_q[a];
      lane_d[2*a+1].s  = ONE_Q30;
      neg_d[2*a]       = sfl3_q[a];
      neg_d[2*a+1]     = cfl3_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PREP_DEPTH-2:0], go_i};
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q   <= u1_d;
    sfl1_q <= sfl1_d;
    cfl1_q <= cfl1_d;
    u2_q   <= u2_d;
    sfl2_q <= sfl1_q;
    cfl2_q <= cfl2_d;
    ts_q   <= u2_q;
    tc_q   <= tc_d;
    sfl3_q <= sfl2_q;
    cfl3_q <= cfl2_q;
    lane_q <= lane_d;
    neg_q  <= neg_d;
  end

  assign ctl_o.valid = vld_q[PREP_DEPTH-1];
  assign ctl_o.neg   = neg_q;
  assign lane_o      = lane_q;

  `ERM_ASSERT_IMP(a_prep_quarter, clk_i, rst_ni, vld_q[PREP_DEPTH-1], ({1'b0, lane_q[LN_SY].t} + {1'b0, lane_q[LN_CY].t} == {1'b0, HALF_PI_Q30}), "sine and cosine arguments do not sum to a quarter turn")

endmodule

`default_nettype wire

// ----- rtl/erm_cell.sv -----
`default_nettype none
`include "euler_rotation_matrix_assert.svh"

module erm_cell import erm_pkg::*; #(
  parameter int SHIFT = RECIP_SH[0]
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [RECIP_W-1:0] recip_i,
  input  ctl_t               ctl_i,
  input  lane_t              lane_i [LANES],
  output ctl_t               ctl_o,
  output lane_t              lane_o [LANES]
);

  ctl_t                    ctl_mid_q, ctl_out_q;
  logic [X2_W+S_W-1:0]     prod_a   [LANES];
  logic [P_W-1:0]          p_mid_d  [LANES];
  logic [P_W-1:0]          p_mid_q  [LANES];
  logic [X2_W-1:0]         x2_mid_q [LANES];
  logic [T_W-1:0]          t_mid_q  [LANES];
  logic [P_W+RECIP_W-1:0]  prod_b   [LANES];
  logic [Q_W-1:0]          quo      [LANES];
  lane_t                   lane_d   [LANES];
  lane_t                   lane_q   [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod_a[i]    = lane_i[i].x2 * lane_i[i].s;
      p_mid_d[i]   = prod_a[i][Q30_SH +: P_W];
      prod_b[i]    = p_mid_q[i] * recip_i;
      quo[i]       = Q_W'(prod_b[i] >> SHIFT);
      lane_d[i].x2 = x2_mid_q[i];
      lane_d[i].t  = t_mid_q[i];
      lane_d[i].s  = ONE_Q30 - {1'b0, quo[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_mid_q <= '0;
      ctl_out_q <= '0;
    end else begin
      ctl_mid_q <= ctl_i;
      ctl_out_q <= ctl_mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      p_mid_q[i]  <= p_mid_d[i];
      x2_mid_q[i] <= lane_i[i].x2;
      t_mid_q[i]  <= lane_i[i].t;
    end
    lane_q <= lane_d;
  end

  assign ctl_o  = ctl_out_q;
  assign lane_o = lane_q;

  `ERM_ASSERT_IMP(a_cell_bounded, clk_i, rst_ni, ctl_out_q.valid, (lane_q[LN_SX].s <= ONE_Q30 && lane_q[LN_CZ].s <= ONE_Q30), "series term left the unit range")

endmodule

`default_nettype wire

// ----- rtl/erm_mix.sv -----
`default_nettype none
`include "euler_rotation_matrix_assert.svh"

module erm_mix import erm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_t               ctl_i,
  input  lane_t              lane_i  [LANES],
  output logic               done_o,
  output logic [ENTRY_W-1:0] entry_o [ENTRIES]
);

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } term_t;

  localparam term_t ZERO_TERM = '{neg: 1'b0, mag: '0};

  function automatic term_t tmul(term_t a, term_t b);
    logic [2*MAG_W-1:0] p;
    term_t r;
    p     = a.mag * b.mag;
    r.neg = a.neg ^ b.neg;
    r.mag = p[Q30_SH +: MAG_W];
    return r;
  endfunction

  function automatic term_t tneg(term_t a);
    term_t r;
    r     = a;
    r.neg = ~a.neg;
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sval(term_t x);
    logic signed [SUM_W-1:0] v;
    v = $signed({{(SUM_W-MAG_W){1'b0}}, x.mag});
    return x.neg ? -v : v;
  endfunction

  logic [MIX_DEPTH-1:0] vld_q;

  logic [2*T_W-1:0] prod1 [LANES];
  term_t            tr1_d [LANES];
  term_t            tr1_q [LANES];

  term_t czsy_q, szsy_q, czcy_q, szcx_q, szsx_q, szcy_q, czcx_q, czsx_q, cysx_q, cycx_q;
  term_t sx2_q, cx2_q, sy2_q;

  term_t pa_d [ENTRIES];
  term_t pb_d [ENTRIES];
  term_t pa_q [ENTRIES];
  term_t pb_q [ENTRIES];

  logic signed [SUM_W-1:0] sum_d [ENTRIES];
  logic signed [SUM_W-1:0] sum_q [ENTRIES];
  logic [SUM_W-1:0]        sum_u [ENTRIES];
  logic [SUM_W-1:0]        rnd_d [ENTRIES];
  logic [SUM_W-1:0]        rnd_q [ENTRIES];
  logic [ENTRIES-1:0]      neg5_q;
  logic [SAT_W-1:0]        rmag  [ENTRIES];
  logic [SAT_W-1:0]        sat   [ENTRIES];
  logic [ENTRY_W-1:0]      out_d [ENTRIES];
  logic [ENTRY_W-1:0]      out_q [ENTRIES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      prod1[i]     = lane_i[i].t * lane_i[i].s;
      tr1_d[i].neg = ctl_i.neg[i];
      tr1_d[i].mag = prod1[i][Q30_SH +: MAG_W];
    end

    pa_d[E00] = czcy_q;
    pb_d[E00] = ZERO_TERM;
    pa_d[E01] = tmul(czsy_q, sx2_q);
    pb_d[E01] = tneg(szcx_q);
    pa_d[E02] = tmul(czsy_q, cx2_q);
    pb_d[E02] = szsx_q;
    pa_d[E10] = szcy_q;
    pb_d[E10] = ZERO_TERM;
    pa_d[E11] = tmul(szsy_q, sx2_q);
    pb_d[E11] = czcx_q;
    pa_d[E12] = tmul(szsy_q, cx2_q);
    pb_d[E12] = tneg(czsx_q);
    pa_d[E20] = tneg(sy2_q);
    pb_d[E20] = ZERO_TERM;
    pa_d[E21] = cysx_q;
    pb_d[E21] = ZERO_TERM;
    pa_d[E22] = cycx_q;
    pb_d[E22] = ZERO_TERM;

    for (int e = 0; e < ENTRIES; e++) begin
      sum_d[e] = sval(pa_q[e]) + sval(pb_q[e]);
      sum_u[e] = $unsigned(sum_q[e]);
      rnd_d[e] = (sum_q[e][SUM_W-1] ? ~sum_u[e] : sum_u[e])
               + (sum_q[e][SUM_W-1] ? RND_HALF + SUM_W'(1) : RND_HALF);
      rmag[e]  = rnd_q[e][RND_SH +: SAT_W];
      sat[e]   = (rmag[e] > Q14_MAX) ? Q14_MAX : rmag[e];
      out_d[e] = neg5_q[e] ? ENTRY_W'(-sat[e]) : ENTRY_W'(sat[e]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MIX_DEPTH-2:0], ctl_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    tr1_q  <= tr1_d;

    czsy_q <= tmul(tr1_q[LN_CZ], tr1_q[LN_SY]);
    szsy_q <= tmul(tr1_q[LN_SZ], tr1_q[LN_SY]);
    czcy_q <= tmul(tr1_q[LN_CZ], tr1_q[LN_CY]);
    szcx_q <= tmul(tr1_q[LN_SZ], tr1_q[LN_CX]);
    szsx_q <= tmul(tr1_q[LN_SZ], tr1_q[LN_SX]);
    szcy_q <= tmul(tr1_q[LN_SZ], tr1_q[LN_CY]);
    czcx_q <= tmul(tr1_q[LN_CZ], tr1_q[LN_CX]);
    czsx_q <= tmul(tr1_q[LN_CZ], tr1_q[LN_SX]);
    cysx_q <= tmul(tr1_q[LN_CY], tr1_q[LN_SX]);
    cycx_q <= tmul(tr1_q[LN_CY], tr1_q[LN_CX]);
    sx2_q  <= tr1_q[LN_SX];
    cx2_q  <= tr1_q[LN_CX];
    sy2_q  <= tr1_q[LN_SY];

    pa_q   <= pa_d;
    pb_q   <= pb_d;
    sum_q  <= sum_d;
    rnd_q  <= rnd_d;
    for (int e = 0; e < ENTRIES; e++) begin
      neg5_q[e] <= sum_q[e][SUM_W-1];
    end
    out_q  <= out_d;
  end

  assign done_o  = vld_q[MIX_DEPTH-1];
  assign entry_o = out_q;

  `ERM_ASSERT_IMP(a_mix_range, clk_i, rst_ni, vld_q[MIX_DEPTH-1], ($signed(out_q[E01]) <= $signed(ENTRY_W'(Q14_MAX)) && $signed(out_q[E01]) >= -$signed(ENTRY_W'(Q14_MAX))), "matrix entry outside unit range")

endmodule

`default_nettype wire

// ----- rtl/euler_rotation_matrix.sv -----
// ZYX Euler angles to rotation matrix R = Rz * Ry * Rx.
//
// Input: a start beat carries angle_x_i, angle_y_i and angle_z_i, each in
// radians times 8192 (two's complement). A beat is taken at a rising edge
// with start high and busy low; busy never rises, so a new triple may be
// given in every cycle.
// Output: done_o is high for exactly one cycle with the nine entries
// m00_o .. m22_o in Q1.14, rounded to nearest and limited to +-1.0. The
// receiver takes the beat at the edge that ends that cycle and cannot
// hold it off.
// Pipeline: the result beat is registered through range reduction and squaring,
// then the row of seven series cells, then the products, sums and
// rounding.
// Throughput: one triple per cycle, set by the fully pipelined cell row.
// Reset: rst_ni clears every valid flag at once; no result beat follows
// until a new start beat is taken. There is no clearing pass.

`default_nettype none
`include "euler_rotation_matrix_assert.svh"

module euler_rotation_matrix import erm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANGLE_W-1:0] angle_x_i,
  input  logic signed [ANGLE_W-1:0] angle_y_i,
  input  logic signed [ANGLE_W-1:0] angle_z_i,
  output logic                      done_o,
  output logic signed [ENTRY_W-1:0] m00_o,
  output logic signed [ENTRY_W-1:0] m01_o,
  output logic signed [ENTRY_W-1:0] m02_o,
  output logic signed [ENTRY_W-1:0] m10_o,
  output logic signed [ENTRY_W-1:0] m11_o,
  output logic signed [ENTRY_W-1:0] m12_o,
  output logic signed [ENTRY_W-1:0] m20_o,
  output logic signed [ENTRY_W-1:0] m21_o,
  output logic signed [ENTRY_W-1:0] m22_o
);

  logic               go;
  logic [ANGLE_W-1:0] angle [AXES];
  ctl_t               ctl_c  [TERMS+1];
  lane_t              lane_c [TERMS+1][LANES];
  logic [ENTRY_W-1:0] entry  [ENTRIES];

  assign busy = 1'b0;
  assign go   = start && !busy;

  assign angle[AX_X] = angle_x_i;
  assign angle[AX_Y] = angle_y_i;
  assign angle[AX_Z] = angle_z_i;

  erm_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .angle_i (angle),
    .ctl_o   (ctl_c[0]),
    .lane_o  (lane_c[0])
  );

  for (genvar g = 0; g < TERMS; g++) begin : g_cell
    erm_cell #(
      .SHIFT (RECIP_SH[g])
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .recip_i (RECIP[g]),
      .ctl_i   (ctl_c[g]),
      .lane_i  (lane_c[g]),
      .ctl_o   (ctl_c[g+1]),
      .lane_o  (lane_c[g+1])
    );
  end

  erm_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_c[TERMS]),
    .lane_i  (lane_c[TERMS]),
    .done_o  (done_o),
    .entry_o (entry)
  );

  assign m00_o = entry[E00];
  assign m01_o = entry[E01];
  assign m02_o = entry[E02];
  assign m10_o = entry[E10];
  assign m11_o = entry[E11];
  assign m12_o = entry[E12];
  assign m20_o = entry[E20];
  assign m21_o = entry[E21];
  assign m22_o = entry[E22];

  `ERM_ASSERT_DLY(a_top_fwd, clk_i, rst_ni, go, LATENCY, done_o, "start beat produced no result beat")
  `ERM_ASSERT_IMP(a_top_back, clk_i, rst_ni, done_o, $past(go, LATENCY), "result beat without a start beat")

endmodule

`default_nettype wire

// ----- tb/tb_euler_rotation_matrix.sv -----
`timescale 1ns / 100ps

module tb_euler_rotation_matrix;
  import erm_pkg::*;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [ENTRIES-1:0][ENTRY_W-1:0] matrix_t;

  typedef struct {
    angle_t  ax;
    angle_t  ay;
    angle_t  az;
    bit      typed;
    matrix_t want;
  } directed_row_t;

  localparam longint PI_Q      = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint ONE_Q     = 64'sd1 << 30;
  localparam int SERIES_TERMS   = 7;
  localparam int RANDOM_ITEMS   = 450;
  localparam int DIRECTED_COUNT = 21;
  localparam int CYCLE_LIMIT    = 200000;
  localparam entry_t Q14_ONE    = 16'sd16384;
  localparam matrix_t UNIT_MATRIX =
    {Q14_ONE, {3{16'h0000}}, Q14_ONE, {3{16'h0000}}, Q14_ONE};

  logic   clk_i;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  angle_t angle_x_i = '0;
  angle_t angle_y_i = '0;
  angle_t angle_z_i = '0;
  logic   done_o;
  entry_t m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  matrix_t     pending_matrices [$];
  matrix_t     seen_matrix;
  matrix_t     oldest_matrix;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          burst_left;

  string entry_names [ENTRIES] =
    '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  directed_row_t directed_rows [DIRECTED_COUNT] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, UNIT_MATRIX},
    '{16'sh7fff, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sh7fff, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sh7fff, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0, '0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0},
    '{16'sd1, -16'sd1, 16'sd1, 1'b0, '0},
    '{16'sd25735, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd25736, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd0, -16'sd25735, 16'sd0, 1'b0, '0},
    '{16'sd0, -16'sd25736, 16'sd0, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd12867, 1'b0, '0},
    '{16'sd0, 16'sd0, 16'sd12868, 1'b0, '0},
    '{-16'sd12867, 16'sd0, 16'sd0, 1'b0, '0},
    '{-16'sd12868, 16'sd0, 16'sd0, 1'b0, '0},
    '{16'sd3000, 16'sd12868, -16'sd5000, 1'b0, '0},
    '{16'sh5555, 16'shaaaa, 16'sh1234, 1'b0, '0},
    '{-16'sd3000, -16'sd12868, 16'sd16000, 1'b0, '0}
  };

  euler_rotation_matrix u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .angle_x_i (angle_x_i),
    .angle_y_i (angle_y_i),
    .angle_z_i (angle_z_i),
    .done_o    (done_o),
    .m00_o     (m00_o),
    .m01_o     (m01_o),
    .m02_o     (m02_o),
    .m10_o     (m10_o),
    .m11_o     (m11_o),
    .m12_o     (m12_o),
    .m20_o     (m20_o),
    .m21_o     (m21_o),
    .m22_o     (m22_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint unsigned series_sine(input longint unsigned t);
    longint unsigned sq;
    longint unsigned s;
    longint unsigned div;
    sq = (t * t) >> 30;
    s  = longint'(ONE_Q);
    for (int k = SERIES_TERMS; k >= 1; k--) begin
      div = longint'(2 * k) * longint'(2 * k + 1);
      s   = longint'(ONE_Q) - ((sq * s) >> 30) / div;
    end
    return (t * s) >> 30;
  endfunction

  function automatic void angle_trig(input angle_t ang, output longint sn, output longint cs);
    longint a;
    longint u;
    longint s;
    longint c;
    bit     neg;
    bit     flip_s;
    bit     flip_c;
    a      = longint'(ang) * 131072;
    neg    = a < 0;
    u      = neg ? -a : a;
    flip_s = 1'b0;
    flip_c = 1'b0;
    if (u > PI_Q) begin
      u      = u - PI_Q;
      flip_s = 1'b1;
      flip_c = 1'b1;
    end
    if (u > HALF_PI_Q) begin
      u      = PI_Q - u;
      flip_c = !flip_c;
    end
    s = longint'(series_sine(u));
    c = longint'(series_sine(HALF_PI_Q - u));
    if (neg) begin
      flip_s = !flip_s;
    end
    sn = flip_s ? -s : s;
    cs = flip_c ? -c : c;
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    longint unsigned ma;
    longint unsigned mb;
    longint          m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m  = longint'((ma * mb) >> 30);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic entry_t to_q14(input longint v);
    longint unsigned mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 32768) >> 16;
    if (mag > 16384) begin
      mag = 16384;
    end
    return (v < 0) ? entry_t'(-longint'(mag)) : entry_t'(mag);
  endfunction

  function automatic matrix_t predict_matrix(input angle_t ax, input angle_t ay,
                                             input angle_t az);
    longint  sx, cx, sy, cy, sz, cz;
    longint  czsy, szsy;
    matrix_t m;
    angle_trig(ax, sx, cx);
    angle_trig(ay, sy, cy);
    angle_trig(az, sz, cz);
    czsy   = q30_mul(cz, sy);
    szsy   = q30_mul(sz, sy);
    m[E00] = to_q14(q30_mul(cz, cy));
    m[E01] = to_q14(q30_mul(czsy, sx) - q30_mul(sz, cx));
    m[E02] = to_q14(q30_mul(czsy, cx) + q30_mul(sz, sx));
    m[E10] = to_q14(q30_mul(sz, cy));
    m[E11] = to_q14(q30_mul(szsy, sx) + q30_mul(cz, cx));
    m[E12] = to_q14(q30_mul(szsy, cx) - q30_mul(cz, sx));
    m[E20] = to_q14(-sy);
    m[E21] = to_q14(q30_mul(cy, sx));
    m[E22] = to_q14(q30_mul(cy, cx));
    return m;
  endfunction

  function automatic angle_t rand_angle();
    int j;
    j = int'($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 9))
      7: begin
        return angle_t'(int'($urandom_range(0, 128)) - 64);
      end
      8: begin
        return angle_t'(($urandom_range(0, 1) ? 25736 : -25736) + j);
      end
      9: begin
        return angle_t'(($urandom_range(0, 1) ? 12868 : -12868) + j);
      end
      default: begin
        return angle_t'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic drive_beat(input angle_t ax, input angle_t ay, input angle_t az,
                            input matrix_t want);
    start     <= 1'b1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_matrices = {pending_matrices, want};
  endtask

  // drop start for a random gap once the current burst runs out
  task automatic rest_after_beat();
    burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 28)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("euler_rotation_matrix verification failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) begin
      if (pending_matrices.size() == 0) begin
        report_mismatch("result beat with nothing outstanding");
      end else begin
        seen_matrix   = {m22_o, m21_o, m20_o, m12_o, m11_o, m10_o, m02_o, m01_o, m00_o};
        oldest_matrix = pending_matrices.pop_front();
        for (int e = 0; e < ENTRIES; e++) begin
          if (seen_matrix[e] !== oldest_matrix[e]) begin
            report_mismatch($sformatf("%s got %0d want %0d", entry_names[e],
                                      $signed(seen_matrix[e]), $signed(oldest_matrix[e])));
          end
        end
      end
    end
  end

  initial begin
    angle_t ax, ay, az;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 8);

    foreach (directed_rows[r]) begin
      drive_beat(directed_rows[r].ax, directed_rows[r].ay, directed_rows[r].az,
                 directed_rows[r].typed ? directed_rows[r].want :
                 predict_matrix(directed_rows[r].ax, directed_rows[r].ay,
                                directed_rows[r].az));
      rest_after_beat();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      ax = rand_angle();
      ay = rand_angle();
      az = rand_angle();
      drive_beat(ax, ay, az, predict_matrix(ax, ay, az));
      if (i == RANDOM_ITEMS / 2) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge clk_i);
      end else if (i != RANDOM_ITEMS - 1) begin
        rest_after_beat();
      end
    end

    start <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("euler_rotation_matrix verification clean");
    end else begin
      $display("euler_rotation_matrix verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/erm_pkg.sv
rtl/erm_prep.sv
rtl/erm_cell.sv
rtl/erm_mix.sv
rtl/euler_rotation_matrix.sv
tb/tb_euler_rotation_matrix.sv
